FILE: src/gepb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepb_pkg: shared types for the greedy edge path builder
// Holds the controller state encoding and the command and status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package gepb_pkg;

	// Controller states, one-hot coded.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_START  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_MERGE1 = 6'b001000,
		ST_MERGE2 = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // store the accepted point
		logic start;   // begin a new pass over all pairs
		logic merge1;  // first half of taking the best pair
		logic merge2;  // second half of taking the best pair
		logic clear;   // return to the empty set after the result transfer
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;   // no point stored yet
		logic scan_idle;  // all pairs issued and the pipeline is empty
		logic found;      // an eligible pair was seen in this pass
		logic done;       // the path has point count minus one edges
	} sts_t;

endpackage

FILE: src/gepb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepb_ctrl: controller of the greedy edge path builder
// Sequences loading, the repeated passes over all pairs, the merges and the
// result transfer.
// ----------------------------------------------------------------------------
module gepb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last_point,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output gepb_pkg::cmd_t  cmd,
	input  gepb_pkg::sts_t  sts
);

	gepb_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gepb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			gepb_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_point) begin
						state_d = sts.cnt_zero ? gepb_pkg::ST_OUT : gepb_pkg::ST_START;
					end
				end
			end
			gepb_pkg::ST_START: begin
				cmd.start = 1'b1;
				state_d = gepb_pkg::ST_SCAN;
			end
			gepb_pkg::ST_SCAN: begin
				if (sts.scan_idle) begin
					state_d = sts.found ? gepb_pkg::ST_MERGE1 : gepb_pkg::ST_OUT;
				end
			end
			gepb_pkg::ST_MERGE1: begin
				cmd.merge1 = 1'b1;
				state_d = gepb_pkg::ST_MERGE2;
			end
			gepb_pkg::ST_MERGE2: begin
				cmd.merge2 = 1'b1;
				state_d = sts.done ? gepb_pkg::ST_OUT : gepb_pkg::ST_START;
			end
			gepb_pkg::ST_OUT: begin
				if (!out_stall) begin
					cmd.clear = 1'b1;
					state_d = gepb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gepb_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != gepb_pkg::ST_IDLE);
	assign out_valid = (state_q == gepb_pkg::ST_OUT);

endmodule

FILE: src/gepb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepb_datapath: point stores, pair scan pipeline and path bookkeeping
// Each pass walks all pairs i<j through a four-stage pipeline and keeps the
// smallest eligible pair; the merge commands then record it.
// ----------------------------------------------------------------------------
module gepb_datapath #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gepb_pkg::cmd_t                cmd,
	output gepb_pkg::sts_t                sts,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	output logic [22:0]                   path_length
);

	localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int DW  = COORD_BITS + 1;
	localparam int MW  = COORD_BITS + 2;
	localparam int SQW = 2 * DW + 1;
	localparam int SW  = ((MW > 23) ? MW : 23) + 1;
	localparam logic [SW-1:0] LenMax = SW'(23'h7FFFFF);

	// Stores and bookkeeping memories.
	logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
	logic [1:0]            deg_mem [MAX_POINTS];
	logic [IW-1:0]         pt_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] deg_vld_q, pt_vld_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] edges_q;
	logic [22:0]   sum_q;

	// Pair counters.
	logic [IW-1:0] ii_q, jj_q;
	logic          issue_q;

	// Pipeline registers.
	logic                  v_s1, v_s2, v_s3;
	logic [COORD_BITS-1:0] xi_s1, xj_s1, yi_s1, yj_s1;
	logic [1:0]            dgi_s1, dgj_s1;
	logic [IW-1:0]         pti_s1, ptj_s1, a_s1, b_s1;
	logic                  dvi_s1, dvj_s1, pvi_s1, pvj_s1;
	logic [DW-1:0]         dx_s2, dy_s2;
	logic [MW-1:0]         man_s2, man_s3;
	logic [SQW-1:0]        sqx_s3, sqy_s3;
	logic [1:0]            dga_s2, dgb_s2, dga_s3, dgb_s3;
	logic [IW-1:0]         a_s2, b_s2, pa_s2, pb_s2, a_s3, b_s3, pa_s3, pb_s3;

	// Best pair of the current pass.
	logic           found_q;
	logic [MW-1:0]  best_man_q;
	logic [SQW-1:0] best_sq_q;
	logic [1:0]     best_dga_q, best_dgb_q;
	logic [IW-1:0]  best_a_q, best_b_q, best_pa_q, best_pb_q;

	// Point loading and count.
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CW'(MAX_POINTS))) begin
			x_mem[cnt_q[IW-1:0]] <= point_x;
			y_mem[cnt_q[IW-1:0]] <= point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else if (cmd.load && (cnt_q < CW'(MAX_POINTS))) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Pair counters walk i<j<n, one pair per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ii_q    <= '0;
			jj_q    <= '0;
			issue_q <= 1'b0;
		end else if (cmd.start) begin
			ii_q    <= '0;
			jj_q    <= IW'(1);
			issue_q <= 1'b1;
		end else if (issue_q) begin
			if (CW'(jj_q) == cnt_q - 1'b1) begin
				if (CW'(ii_q) == cnt_q - CW'(2)) begin
					issue_q <= 1'b0;
				end else begin
					ii_q <= ii_q + 1'b1;
					jj_q <= ii_q + IW'(2);
				end
			end else begin
				jj_q <= jj_q + 1'b1;
			end
		end
	end

	// Stage 1: registered reads of both endpoints.
	always_ff @(posedge clk) begin
		xi_s1  <= x_mem[ii_q];
		xj_s1  <= x_mem[jj_q];
		yi_s1  <= y_mem[ii_q];
		yj_s1  <= y_mem[jj_q];
		dgi_s1 <= deg_mem[ii_q];
		dgj_s1 <= deg_mem[jj_q];
		pti_s1 <= pt_mem[ii_q];
		ptj_s1 <= pt_mem[jj_q];
		dvi_s1 <= deg_vld_q[ii_q];
		dvj_s1 <= deg_vld_q[jj_q];
		pvi_s1 <= pt_vld_q[ii_q];
		pvj_s1 <= pt_vld_q[jj_q];
		a_s1   <= ii_q;
		b_s1   <= jj_q;
	end

	// Stage 2 inputs: entries never written read as degree zero, own end.
	logic [1:0]    dgi, dgj;
	logic [IW-1:0] pti, ptj;
	logic [DW-1:0] ddx, ddy, adx, ady;
	logic          elig;

	always_comb begin
		dgi  = dvi_s1 ? dgi_s1 : 2'd0;
		dgj  = dvj_s1 ? dgj_s1 : 2'd0;
		pti  = pvi_s1 ? pti_s1 : a_s1;
		ptj  = pvj_s1 ? ptj_s1 : b_s1;
		ddx  = {xi_s1[COORD_BITS-1], xi_s1} - {xj_s1[COORD_BITS-1], xj_s1};
		ddy  = {yi_s1[COORD_BITS-1], yi_s1} - {yj_s1[COORD_BITS-1], yj_s1};
		// Absolute differences at their own width.
		adx  = ddx[DW-1] ? (~ddx + 1'b1) : ddx;
		ady  = ddy[DW-1] ? (~ddy + 1'b1) : ddy;
		// Both endpoints free and not the two ends of one path.
		elig = (dgi < 2'd2) && (dgj < 2'd2) && (pti != b_s1);
	end

	always_ff @(posedge clk) begin
		dx_s2  <= adx;
		dy_s2  <= ady;
		man_s2 <= MW'(adx) + MW'(ady);
		dga_s2 <= dgi;
		dgb_s2 <= dgj;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		pa_s2  <= pti;
		pb_s2  <= ptj;
	end

	// Stage 3: squares of the distances.
	always_ff @(posedge clk) begin
		sqx_s3 <= SQW'(dx_s2 * dx_s2);
		sqy_s3 <= SQW'(dy_s2 * dy_s2);
		man_s3 <= man_s2;
		dga_s3 <= dga_s2;
		dgb_s3 <= dgb_s2;
		a_s3   <= a_s2;
		b_s3   <= b_s2;
		pa_s3  <= pa_s2;
		pb_s3  <= pb_s2;
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1 && elig;
			v_s3 <= v_s2;
		end
	end

	// Stage 4: keep the smallest pair; earlier pairs win ties.
	logic [SQW-1:0] sq_sum;
	logic           better;

	always_comb begin
		sq_sum = sqx_s3 + sqy_s3;
		better = !found_q || (man_s3 < best_man_q)
			|| ((man_s3 == best_man_q) && (sq_sum < best_sq_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (v_s3) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && better) begin
			best_man_q <= man_s3;
			best_sq_q  <= sq_sum;
			best_dga_q <= dga_s3;
			best_dgb_q <= dgb_s3;
			best_a_q   <= a_s3;
			best_b_q   <= b_s3;
			best_pa_q  <= pa_s3;
			best_pb_q  <= pb_s3;
		end
	end

	// Merge: bump degrees and link the new path ends to each other.
	always_ff @(posedge clk) begin
		if (cmd.merge1) begin
			deg_mem[best_a_q]  <= best_dga_q + 1'b1;
			pt_mem[best_pa_q]  <= best_pb_q;
		end else if (cmd.merge2) begin
			deg_mem[best_b_q]  <= best_dgb_q + 1'b1;
			pt_mem[best_pb_q]  <= best_pa_q;
		end
	end

	logic [SW-1:0] sum_next;
	assign sum_next = SW'(sum_q) + SW'(best_man_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
			pt_vld_q  <= '0;
			edges_q   <= '0;
			sum_q     <= '0;
		end else if (cmd.clear) begin
			deg_vld_q <= '0;
			pt_vld_q  <= '0;
			edges_q   <= '0;
			sum_q     <= '0;
		end else if (cmd.merge1) begin
			deg_vld_q[best_a_q]  <= 1'b1;
			pt_vld_q[best_pa_q]  <= 1'b1;
			edges_q              <= edges_q + 1'b1;
			sum_q <= (sum_next > LenMax) ? 23'h7FFFFF : sum_next[22:0];
		end else if (cmd.merge2) begin
			deg_vld_q[best_b_q]  <= 1'b1;
			pt_vld_q[best_pb_q]  <= 1'b1;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.cnt_zero  = (cnt_q == '0);
		sts.scan_idle = !issue_q && !v_s1 && !v_s2 && !v_s3;
		sts.found     = found_q;
		sts.done      = (edges_q + 1'b1 == cnt_q);
	end

	assign path_length = sum_q;

endmodule

FILE: src/greedy_edge_path_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_edge_path_builder: greedy edge path over a set of 2-D points
// Stores points until the marked last one, then builds a path by greedily
// taking the shortest free pair and reports its Manhattan length.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | point_x, point_y, last_point
//   out     | output    | out_valid/out_stall| path_length
//
// Points are taken one per cycle while in_stall is low. After the last point
// each edge costs one pass over all n(n-1)/2 pairs plus the start, pipeline
// drain and merge steps. The single pair pipeline and its memory read ports
// set the length of each pass.
// Reset clears all control state at once; no clearing pass is needed.
// While the result waits under out_stall, in_stall stays high.
// ----------------------------------------------------------------------------
module greedy_edge_path_builder #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [22:0]                   path_length
);

	gepb_pkg::cmd_t cmd;
	gepb_pkg::sts_t sts;

	// Controller.
	gepb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (last_point),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Datapath.
	gepb_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.point_x     (point_x),
		.point_y     (point_y),
		.path_length (path_length)
	);

endmodule

FILE: src/gepb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepb_port_checks: port checks for the greedy edge path builder
// Watches the handshakes and the busy behaviour seen at the top level.
// ----------------------------------------------------------------------------
module gepb_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_point,
	input logic        out_valid,
	input logic        out_stall,
	input logic [22:0] path_length
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(path_length))
		else $error("result changed while stalled");

	// The last point transfer makes the block busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_point |=> in_stall)
		else $error("input taken after the last point");

	// No point is taken while a result is offered.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result waits");

endmodule

bind greedy_edge_path_builder gepb_port_checks u_gepb_port_checks (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_point  (last_point),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.path_length (path_length)
);
